/* rtl/srm_pkg.sv */
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants for the string rotation match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

  localparam int MAX_LEN_DEF = 64;

  // Command codes carried in item.cmd
  localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPARE       = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic is_rotation;
    logic overflow;
  } result_t;

  // Sequencer to top-level status
  typedef struct packed {
    logic busy;
    logic done;
    logic match;
  } srm_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } srm_state_t;

endpackage

`default_nettype wire

/* rtl/srm_ram.sv */
// ----------------------------------------------------------------------------
// srm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = srm_pkg::MAX_LEN_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/srm_ctrl.sv */
// ----------------------------------------------------------------------------
// srm_ctrl
// Rotation search sequencer: walks start offsets and byte positions, driving
// both buffer read ports and one shared byte comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_ctrl #(
  parameter int MAX_LEN = srm_pkg::MAX_LEN_DEF,
  localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [AW-1:0]       last_idx,
  input  wire logic [7:0]          first_byte,
  input  wire logic [7:0]          second_byte,
  output logic      [AW-1:0]       first_addr,
  output logic      [AW-1:0]       second_addr,
  output srm_pkg::srm_status_t     status
);

  srm_pkg::srm_state_t state, state_next;

  logic [AW-1:0] last;
  logic [AW-1:0] rot;   // start offset
  logic [AW-1:0] pos;   // position in second string
  logic [AW-1:0] idx;   // (rot + pos) mod n in first string

  logic same;
  logic last_pos;
  logic last_rot;

  assign same     = (first_byte == second_byte);
  assign last_pos = (pos == last);
  assign last_rot = (rot == last);

  assign first_addr  = idx;
  assign second_addr = pos;

  always_comb begin
    state_next = state;
    unique case (state)
      srm_pkg::ST_IDLE: begin
        if (start) state_next = srm_pkg::ST_READ;
      end
      srm_pkg::ST_READ: begin
        state_next = srm_pkg::ST_CHECK;
      end
      srm_pkg::ST_CHECK: begin
        if ((same && last_pos) || (!same && last_rot)) begin
          state_next = srm_pkg::ST_IDLE;
        end else begin
          state_next = srm_pkg::ST_READ;
        end
      end
      default: state_next = srm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    status.busy  = (state != srm_pkg::ST_IDLE);
    status.done  = 1'b0;
    status.match = 1'b0;
    if (state == srm_pkg::ST_CHECK) begin
      status.done  = (same && last_pos) || (!same && last_rot);
      status.match = same && last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srm_pkg::ST_IDLE && start) begin
      last <= last_idx;
      rot  <= '0;
      pos  <= '0;
      idx  <= '0;
    end else if (state == srm_pkg::ST_CHECK) begin
      if (same) begin
        // advance along the current rotation
        pos <= pos + 1'b1;
        idx <= (idx == last) ? '0 : idx + 1'b1;
      end else begin
        // try the next start offset
        rot <= rot + 1'b1;
        pos <= '0;
        idx <= rot + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/string_rotation_match_unit.sv */
// ----------------------------------------------------------------------------
// string_rotation_match_unit
// Builds two byte strings from append beats and reports on compare whether
// the second is a cyclic rotation of the first.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  item     | item_valid / item_ready     | item   (cmd, ch)
//  result   | result_valid / result_ready | result (is_rotation, overflow)
//
// Append beats write their byte into a buffer unless it is full. A compare beat
// with unequal or zero lengths answers from the result register in the next
// cycle; otherwise the search reads one byte pair at a time, a READ and then
// a CHECK state per pair, through the single byte comparator behind the
// registered read ports of the two buffers. item_ready is low during the
// search, and a compare beat is held off while an earlier result still
// waits. Reset clears lengths, overflow and control.
`default_nettype none

module string_rotation_match_unit #(
  parameter int MAX_LEN = srm_pkg::MAX_LEN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire srm_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output srm_pkg::result_t      result
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0] first_length;
  logic [LW-1:0] second_length;
  logic          overflow_seen;

  logic [7:0]    first_byte;
  logic [7:0]    second_byte;
  logic [AW-1:0] first_addr;
  logic [AW-1:0] second_addr;

  srm_pkg::srm_status_t status;

  logic accept;
  logic is_cmp;
  logic app_first;
  logic app_second;
  logic first_full;
  logic second_full;
  logic len_equal;
  logic start;
  logic [AW-1:0] last_idx;

  assign is_cmp     = (item.cmd == srm_pkg::CMD_COMPARE);
  assign item_ready = !status.busy && !(is_cmp && result_valid);
  assign accept     = item_valid && item_ready;

  assign first_full  = (first_length == LW'(MAX_LEN));
  assign second_full = (second_length == LW'(MAX_LEN));
  assign app_first   = accept && (item.cmd == srm_pkg::CMD_APPEND_FIRST);
  assign app_second  = accept && (item.cmd == srm_pkg::CMD_APPEND_SECOND);

  assign len_equal = (first_length == second_length);
  assign start     = accept && is_cmp && len_equal && (first_length != '0);
  assign last_idx  = AW'(first_length - 1'b1);

  srm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_ram (
    .clk     (clk),
    .wr_en   (app_first && !first_full),
    .wr_addr (first_length[AW-1:0]),
    .wr_data (item.ch),
    .rd_addr (first_addr),
    .rd_data (first_byte)
  );

  srm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_ram (
    .clk     (clk),
    .wr_en   (app_second && !second_full),
    .wr_addr (second_length[AW-1:0]),
    .wr_data (item.ch),
    .rd_addr (second_addr),
    .rd_data (second_byte)
  );

  srm_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_idx    (last_idx),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .first_addr  (first_addr),
    .second_addr (second_addr),
    .status      (status)
  );

  // lengths and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
    end else if (accept && is_cmp) begin
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (app_first) begin
        if (first_full) overflow_seen <= 1'b1;
        else            first_length  <= first_length + 1'b1;
      end
      if (app_second) begin
        if (second_full) overflow_seen <= 1'b1;
        else             second_length <= second_length + 1'b1;
      end
    end
  end

  // result register; overflow is captured at the compare beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && is_cmp && !start) begin
      result_valid <= 1'b1;
    end else if (status.done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_cmp) begin
      result.overflow    <= overflow_seen;
      result.is_rotation <= len_equal;
    end else if (status.done) begin
      result.is_rotation <= status.match;
    end
  end

`ifndef SYNTH
  a_done_gives_result: assert property (
    @(posedge clk) disable iff (rst) status.done |=> result_valid
  ) else $error("search finished without a result");

  a_busy_no_pending: assert property (
    @(posedge clk) disable iff (rst) status.busy |-> !result_valid
  ) else $error("result pending while search runs");

  a_addr_in_range: assert property (
    @(posedge clk) disable iff (rst)
      status.busy |-> (first_addr <= u_ctrl.last) && (second_addr <= u_ctrl.last)
  ) else $error("read address beyond string length");
`endif

endmodule

`default_nettype wire

/* tb/string_rotation_match_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_rotation_match_unit_tb
// Loads pairs of byte strings through the item channel, mostly as rotations,
// near rotations and length mismatches of each other, with full buffers,
// dropped bytes and unused commands mixed in. A scoreboard tracks both
// strings and the drop flag and checks every compare verdict in order.
// ----------------------------------------------------------------------------
module string_rotation_match_unit_tb;
  import srm_pkg::*;

  localparam int STR_CAP = MAX_LEN_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 64;

  class rotation_scoreboard;
    logic [7:0] first_str[$];
    logic [7:0] second_str[$];
    bit dropped_byte;
    result_t pending_verdicts[$];
    int errors;

    function bit second_is_rotation();
      int n;
      bit same;
      n = first_str.size();
      if (n != second_str.size()) return 1'b0;
      if (n == 0) return 1'b1;
      for (int r = 0; r < n; r++) begin
        same = 1'b1;
        for (int k = 0; k < n && same; k++) begin
          if (first_str[(r + k) % n] != second_str[k]) same = 1'b0;
        end
        if (same) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(item_t beat);
      result_t verdict;
      case (beat.cmd)
        CMD_APPEND_FIRST: begin
          if (first_str.size() < STR_CAP) first_str.push_back(beat.ch);
          else dropped_byte = 1'b1;
        end
        CMD_APPEND_SECOND: begin
          if (second_str.size() < STR_CAP) second_str.push_back(beat.ch);
          else dropped_byte = 1'b1;
        end
        CMD_COMPARE: begin
          verdict.is_rotation = second_is_rotation();
          verdict.overflow = dropped_byte;
          pending_verdicts.push_back(verdict);
          first_str.delete();
          second_str.delete();
          dropped_byte = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with none pending: is_rotation=%b overflow=%b",
                 $time, got.is_rotation, got.overflow);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.is_rotation !== want.is_rotation) begin
        $display("%0t: is_rotation mismatch: expected %b, actual %b",
                 $time, want.is_rotation, got.is_rotation);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow mismatch: expected %b, actual %b",
                 $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;

  rotation_scoreboard scoreboard = new();
  int send_idle_pct = 12;
  int recv_idle_pct = 67;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;

  string_rotation_match_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  // Drive one item beat and hold it until the block takes it.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
    item_t beat;
    beat.cmd = cmd;
    beat.ch = ch;
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      item <= item_t'(10'($urandom));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item <= beat;
    do @(posedge clk); while (item_ready !== 1'b1);
    scoreboard.note_item(beat);
    if (cmd != CMD_UNUSED) sent_count++;
  endtask

  function automatic logic [7:0] pick_byte(bit narrow, logic [7:0] sym0, logic [7:0] sym1);
    if (narrow) return $urandom_range(1) ? sym0 : sym1;
    return 8'($urandom_range(255));
  endfunction

  task automatic directed_checks();
    send_item(CMD_COMPARE, 8'h00);                    // both empty
    send_item(CMD_UNUSED, 8'hFF);
    send_item(CMD_APPEND_FIRST, 8'h00);               // zero byte is data
    send_item(CMD_APPEND_SECOND, 8'h00);
    send_item(CMD_COMPARE, 8'hFF);
    send_item(CMD_APPEND_FIRST, 8'hFF);               // non-empty against empty
    send_item(CMD_COMPARE, 8'h55);
    send_item(CMD_APPEND_SECOND, 8'hFF);              // empty against non-empty
    send_item(CMD_COMPARE, 8'hAA);
    send_item(CMD_APPEND_FIRST, 8'h01);
    send_item(CMD_APPEND_FIRST, 8'h80);
    send_item(CMD_APPEND_FIRST, 8'hFF);
    send_item(CMD_APPEND_SECOND, 8'hFF);
    send_item(CMD_APPEND_SECOND, 8'h01);
    send_item(CMD_APPEND_SECOND, 8'h80);
    send_item(CMD_COMPARE, 8'h00);
    send_item(CMD_APPEND_FIRST, 8'h01);
    send_item(CMD_APPEND_SECOND, 8'h80);
    send_item(CMD_UNUSED, 8'h00);
    send_item(CMD_APPEND_FIRST, 8'h80);
    send_item(CMD_APPEND_SECOND, 8'h80);
    send_item(CMD_COMPARE, 8'h00);
    send_item(CMD_COMPARE, 8'h00);
  endtask

  // One string pair followed by a compare; a few calls send loose noise instead.
  task automatic string_pair_sequence();
    logic [7:0] a_str[$];
    logic [7:0] b_str[$];
    logic [7:0] sym0;
    logic [7:0] sym1;
    int n, roll, rot, ia, ib, j;
    bit narrow;
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    roll = $urandom_range(99);
    if (roll < 4) n = STR_CAP;
    else if (roll < 10) n = 0;
    else if (roll < 22) n = $urandom_range(9, 20);
    else n = $urandom_range(1, 8);
    narrow = ($urandom_range(2) == 0);
    sym0 = 8'($urandom_range(255));
    sym1 = 8'($urandom_range(255));
    for (j = 0; j < n; j++) a_str.push_back(pick_byte(narrow, sym0, sym1));
    rot = (n > 0) ? $urandom_range(n - 1) : 0;
    for (j = 0; j < n; j++) b_str.push_back(a_str[(rot + j) % n]);
    roll = $urandom_range(99);
    if (roll < 20 && n > 0) begin
      j = $urandom_range(n - 1);
      b_str[j] = b_str[j] ^ (8'd1 << $urandom_range(7));
    end else if (roll < 30) begin
      if (n > 0 && $urandom_range(1)) void'(b_str.pop_back());
      else b_str.push_back(pick_byte(narrow, sym0, sym1));
    end else if (roll < 40) begin
      b_str.delete();
      for (j = 0; j < n; j++) b_str.push_back(pick_byte(narrow, sym0, sym1));
    end
    // Push full strings past capacity now and then.
    if (n == STR_CAP) begin
      repeat ($urandom_range(2)) a_str.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(2)) b_str.push_back(8'($urandom_range(255)));
    end
    ia = 0;
    ib = 0;
    while (ia < a_str.size() || ib < b_str.size()) begin
      if ($urandom_range(99) < 3) send_item(CMD_UNUSED, 8'($urandom_range(255)));
      if (ib >= b_str.size() || (ia < a_str.size() && $urandom_range(1))) begin
        send_item(CMD_APPEND_FIRST, a_str[ia]);
        ia++;
      end else begin
        send_item(CMD_APPEND_SECOND, b_str[ib]);
        ib++;
      end
    end
    send_item(CMD_COMPARE, 8'($urandom_range(255)));
  endtask

  task automatic random_phase(input int unsigned target);
    while (sent_count < target) string_pair_sequence();
  endtask

  // Check result beats and stall the result channel.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && result_ready) scoreboard.check_result(result);
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("string_rotation_match_unit test failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    directed_checks();
    random_phase(560);
    send_idle_pct = 67;
    recv_idle_pct = 12;
    random_phase(1110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(1670);
    item_valid <= 1'b0;
    while (scoreboard.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.errors == 0 && scoreboard.pending_verdicts.size() == 0) begin
      $display("string_rotation_match_unit test passed");
    end else begin
      if (scoreboard.pending_verdicts.size() != 0)
        $display("%0t: %0d results never arrived", $time, scoreboard.pending_verdicts.size());
      $display("string_rotation_match_unit test failed");
    end
    $finish;
  end

endmodule
